### src/assert_macros.svh
// Assertion macros shared by the RTL of the indexed insert/delete array.
// Plain text macros only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define IIDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define IIDA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### src/iida_pkg.sv
// Shared types and codes for the indexed insert/delete array.
// No dependencies.
package iida_pkg;

  // Request kinds carried in req_type.
  typedef enum logic [2:0] {
    REQ_APPEND = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_EDIT   = 3'd2,
    REQ_DELETE = 3'd3,
    REQ_READ   = 3'd4,
    REQ_CHECK  = 3'd5
  } req_kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_IDX = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // Operation broadcast to every storage cell.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_WRITE  = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_DELETE = 2'd3
  } cell_op_e;

  // Source of the read_data field of a result.
  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_CELL = 2'd1,
    SRC_POS  = 2'd2,
    SRC_ONES = 2'd3
  } rd_src_e;

  // Control broadcast along the row of cells.
  typedef struct packed {
    cell_op_e op;
    logic     rd_en;
    logic     sample;
  } cell_ctrl_t;

  localparam int unsigned WordW = 32;
  localparam int unsigned PosW  = 7;
  localparam int unsigned KindW = 3;
  localparam int unsigned StatW = 2;

endpackage

### src/iida_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on iida_pkg for field widths.
interface iida_req_if;
  import iida_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KindW-1:0]         req_type;
  logic [PosW-1:0]          position;
  logic signed [WordW-1:0]  value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink   (input valid, req_type, position, value, output ready);
endinterface

interface iida_rsp_if;
  import iida_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WordW-1:0]  read_data;
  logic [StatW-1:0]         status;
  logic [PosW-1:0]          count;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, read_data, status, count, is_empty, is_full, input ready);
  modport sink   (input valid, read_data, status, count, is_empty, is_full, output ready);
endinterface

### src/iida_cell.sv
// One storage cell of the shifting array: holds one word, trades with its neighbors.
// Depends on iida_pkg.
module iida_cell #(
  parameter int unsigned IdxW = 6
) (
  input  logic                          clk_i,
  input  iida_pkg::cell_ctrl_t          ctrl_i,
  input  logic [IdxW-1:0]               idx_i,
  input  logic [IdxW-1:0]               my_idx_i,
  input  logic [iida_pkg::WordW-1:0]    value_i,
  input  logic [iida_pkg::WordW-1:0]    left_i,
  input  logic [iida_pkg::WordW-1:0]    right_i,
  output logic [iida_pkg::WordW-1:0]    data_o,
  output logic [iida_pkg::WordW-1:0]    rd_o
);
  import iida_pkg::*;

  logic [WordW-1:0] data_q, data_d;
  logic [WordW-1:0] rd_q;
  logic             hit;
  logic             above;

  assign hit   = (my_idx_i == idx_i);
  assign above = (my_idx_i > idx_i);

  // Pick the next word: hold, load, take from below or from above.
  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_WRITE: begin
        if (hit) data_d = value_i;
      end
      CELL_INSERT: begin
        if (hit) begin
          data_d = value_i;
        end else if (above) begin
          data_d = left_i;
        end
      end
      CELL_DELETE: begin
        if (hit || above) data_d = right_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // Capture the addressed word for a read; other cells drive zero.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.sample) begin
      rd_q <= (ctrl_i.rd_en && hit) ? data_q : '0;
    end
  end

  assign data_o = data_q;
  assign rd_o   = rd_q;

endmodule

### src/indexed_insert_delete_array.sv
// Indexed insert/delete array: a row of CAPACITY word cells kept packed from index 0, plus a
// fill count. Append, insert, edit, delete, read and index check each finish in the cycle the
// transaction is accepted, since every cell shifts up or down in parallel with its neighbor;
// the block takes one transaction per cycle while the result side is not stalled, and returns
// its result through stage 1 (the latch of the addressed cell) and then the output register. A failed
// request leaves the array untouched and reports full, invalid index or empty in status.
// Depends on iida_pkg, iida_if, iida_cell and assert_macros.svh.
`include "assert_macros.svh"

module indexed_insert_delete_array #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  iida_req_if.sink      req_i,
  iida_rsp_if.source    rsp_o
);
  import iida_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Fill count and pipeline control.
  logic [CntW-1:0]  count_q, count_d;
  logic             s1_valid_q;
  logic             out_valid_q;
  logic             s1_adv;
  logic             accept;

  // Request decode.
  logic [CmpW-1:0]  pos_w, cnt_w;
  logic             full, empty, pos_lt, pos_le;
  cell_op_e         op;
  logic [IdxW-1:0]  idx;
  status_e          status;
  rd_src_e          src;
  cell_ctrl_t       ctrl;

  // Stage 1 and output registers.
  status_e          s1_status_q;
  rd_src_e          s1_src_q;
  logic [PosW-1:0]  s1_pos_q;
  logic [CntW-1:0]  s1_count_q;
  logic [WordW-1:0] rd_word;
  logic [WordW-1:0] out_data_q;
  status_e          out_status_q;
  logic [PosW-1:0]  out_count_q;
  logic             out_empty_q;
  logic             out_full_q;
  logic [CmpW-1:0]  s1_count_w;

  // Cell row wiring.
  logic [WordW-1:0] cell_data [CAPACITY];
  logic [WordW-1:0] cell_rd   [CAPACITY];

  assign s1_adv      = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign accept      = req_i.valid && req_i.ready;

  assign pos_w  = CmpW'(req_i.position);
  assign cnt_w  = CmpW'(count_q);
  assign full   = (count_q == CntW'(CAPACITY));
  assign empty  = (count_q == '0);
  assign pos_lt = (pos_w < cnt_w);
  assign pos_le = (pos_w <= cnt_w);

  // Decode the request against the current fill count.
  always_comb begin
    op      = CELL_HOLD;
    idx     = pos_w[IdxW-1:0];
    status  = ST_OK;
    src     = SRC_ZERO;
    count_d = count_q;
    case (req_i.req_type)
      REQ_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          op      = CELL_INSERT;
          idx     = count_q[IdxW-1:0];
          count_d = count_q + 1'b1;
        end
      end
      REQ_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (!pos_le) begin
          status = ST_BAD_IDX;
        end else begin
          op      = CELL_INSERT;
          count_d = count_q + 1'b1;
        end
      end
      REQ_EDIT: begin
        if (pos_lt) op = CELL_WRITE;
        else        status = ST_BAD_IDX;
      end
      REQ_DELETE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (pos_lt) begin
          op      = CELL_DELETE;
          count_d = count_q - 1'b1;
        end else begin
          status = ST_BAD_IDX;
        end
      end
      REQ_READ: begin
        if (pos_lt) begin
          src = SRC_CELL;
        end else begin
          src    = SRC_ONES;
          status = ST_BAD_IDX;
        end
      end
      REQ_CHECK: begin
        if (pos_lt) begin
          src = SRC_POS;
        end else begin
          src    = SRC_ONES;
          status = ST_BAD_IDX;
        end
      end
      default: begin
        op = CELL_HOLD;
      end
    endcase
  end

  // Broadcast only on an accepted transaction.
  assign ctrl.op     = accept ? op : CELL_HOLD;
  assign ctrl.rd_en  = (src == SRC_CELL);
  assign ctrl.sample = accept;

  // Row of cells; the ends see zero beyond the array.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WordW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    iida_cell #(
      .IdxW (IdxW)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .idx_i    (idx),
      .my_idx_i (IdxW'(g)),
      .value_i  (req_i.value),
      .left_i   (left_w),
      .right_i  (right_w),
      .data_o   (cell_data[g]),
      .rd_o     (cell_rd[g])
    );
  end

  // Combine the masked cell words; at most one is nonzero.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  // Advance the fill count and the pipeline valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) count_q <= count_d;
      if (req_i.ready) s1_valid_q <= accept;
      if (s1_adv) out_valid_q <= s1_valid_q;
    end
  end

  // Hold the result fields of the transaction in flight.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= status;
      s1_src_q    <= src;
      s1_pos_q    <= req_i.position;
      s1_count_q  <= count_d;
    end
  end

  assign s1_count_w = CmpW'(s1_count_q);

  // Load the output register.
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      case (s1_src_q)
        SRC_CELL: out_data_q <= rd_word;
        SRC_POS:  out_data_q <= WordW'(s1_pos_q);
        SRC_ONES: out_data_q <= '1;
        default:  out_data_q <= '0;
      endcase
      out_status_q <= s1_status_q;
      out_count_q  <= s1_count_w[PosW-1:0];
      out_empty_q  <= (s1_count_q == '0);
      out_full_q   <= (s1_count_q == CntW'(CAPACITY));
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = signed'(out_data_q);
  assign rsp_o.status    = out_status_q;
  assign rsp_o.count     = out_count_q;
  assign rsp_o.is_empty  = out_empty_q;
  assign rsp_o.is_full   = out_full_q;

  // Checks.
  `IIDA_ASSERT_ALWAYS(a_reset_clear, !rst_ni |-> (count_q == '0 && !s1_valid_q && !out_valid_q), "reset did not clear control state")
  `IIDA_ASSERT(a_count_bound, count_q <= CntW'(CAPACITY), "fill count above capacity")
  `IIDA_ASSERT(a_full_hold, (accept && full && (req_i.req_type == REQ_APPEND || req_i.req_type == REQ_INSERT)) |=> $stable(count_q), "count moved on a full array")
  `IIDA_ASSERT(a_delete_dec, (accept && ctrl.op == CELL_DELETE) |=> (count_q == $past(count_q) - 1'b1), "delete did not drop the count")
  `IIDA_ASSERT(a_no_overrun, (s1_valid_q && !s1_adv) |-> !req_i.ready, "stage 1 overwritten while stalled")

endmodule

### tb/sv/tb_indexed_insert_delete_array.sv
// Self-checking testbench for indexed_insert_delete_array: directed and random request
// traffic on the request channel, each result checked against a shadow copy of the array.
// Depends on iida_pkg, iida_if and the indexed_insert_delete_array RTL.
module tb_indexed_insert_delete_array;
  import iida_pkg::*;

  localparam int unsigned Capacity = 64;
  localparam int unsigned PosMax   = (1 << PosW) - 1;
  // Request kinds the block ignores.
  localparam logic [KindW-1:0] REQ_UNUSED_6 = 3'd6;
  localparam logic [KindW-1:0] REQ_UNUSED_7 = 3'd7;
  localparam logic signed [WordW-1:0] WORD_MIN  = 32'sh8000_0000;
  localparam logic signed [WordW-1:0] WORD_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [WordW-1:0] WORD_ONES = -32'sd1;

  typedef struct {
    logic signed [WordW-1:0] read_data;
    status_e                 status;
    logic [PosW-1:0]         count;
    logic                    is_empty;
    logic                    is_full;
  } array_result_t;

  logic clk_i;
  logic rst_ni;

  iida_req_if req_if ();
  iida_rsp_if rsp_if ();

  indexed_insert_delete_array #(.CAPACITY(Capacity)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow of the array contents and fill count
  logic signed [WordW-1:0] shadow_words [Capacity];
  int unsigned             shadow_count;
  array_result_t           pending_results [$];

  int tx_idle_pct;
  int rx_idle_pct;
  int mismatches = 0;

  // Clock: period 12
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Apply one request to the shadow array and return the result it should produce
  function automatic array_result_t apply_request(logic [KindW-1:0] kind, logic [PosW-1:0] pos,
                                                  logic signed [WordW-1:0] val);
    array_result_t res;
    int unsigned   p;
    p = pos;
    res.read_data = '0;
    res.status    = ST_OK;
    case (kind)
      REQ_APPEND: begin
        if (shadow_count >= Capacity) begin
          res.status = ST_FULL;
        end else begin
          shadow_words[shadow_count] = val;
          shadow_count++;
        end
      end
      REQ_INSERT: begin
        if (shadow_count >= Capacity) begin
          res.status = ST_FULL;
        end else if (p > shadow_count) begin
          res.status = ST_BAD_IDX;
        end else begin
          for (int i = shadow_count; i > p; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[p] = val;
          shadow_count++;
        end
      end
      REQ_EDIT: begin
        if (p < shadow_count) shadow_words[p] = val;
        else res.status = ST_BAD_IDX;
      end
      REQ_DELETE: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else if (p < shadow_count) begin
          for (int i = p; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
          shadow_count--;
        end else begin
          res.status = ST_BAD_IDX;
        end
      end
      REQ_READ: begin
        if (p < shadow_count) begin
          res.read_data = shadow_words[p];
        end else begin
          res.read_data = WORD_ONES;
          res.status    = ST_BAD_IDX;
        end
      end
      REQ_CHECK: begin
        if (p < shadow_count) begin
          res.read_data = WordW'(p);
        end else begin
          res.read_data = WORD_ONES;
          res.status    = ST_BAD_IDX;
        end
      end
      default: ;
    endcase
    res.count    = shadow_count[PosW-1:0];
    res.is_empty = (shadow_count == 0);
    res.is_full  = (shadow_count >= Capacity);
    return res;
  endfunction

  // Drive one request, hold it until accepted, then record its expected result.
  // Valid is left high on return so back-to-back requests need no extra edge.
  task automatic send_request(logic [KindW-1:0] kind, logic [PosW-1:0] pos,
                              logic signed [WordW-1:0] val);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.position <= pos;
    req_if.value    <= val;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pending_results.push_back(apply_request(kind, pos, val));
  endtask

  // Random word, with the extremes mixed in
  function automatic logic signed [WordW-1:0] pick_word();
    case ($urandom_range(0, 19))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return WORD_ONES;
      default: return $urandom();
    endcase
  endfunction

  // Position mostly at or below the fill count, sometimes anywhere in the field
  function automatic logic [PosW-1:0] pick_pos();
    if ($urandom_range(0, 99) < 80) return PosW'($urandom_range(0, shadow_count));
    return PosW'($urandom_range(0, PosMax));
  endfunction

  // Requests against an empty array, plus the ignored request kinds
  task automatic test_empty_array();
    send_request(REQ_READ, '0, '0);
    send_request(REQ_CHECK, '0, '0);
    send_request(REQ_DELETE, '0, '0);
    send_request(REQ_EDIT, '0, WORD_MAX);
    send_request(REQ_INSERT, 7'd1, WORD_MAX);
    send_request(REQ_UNUSED_6, PosMax[PosW-1:0], WORD_ONES);
    send_request(REQ_UNUSED_7, '0, WORD_MIN);
    send_request(REQ_INSERT, '0, WORD_MIN);
    send_request(REQ_DELETE, PosMax[PosW-1:0], '0);
    send_request(REQ_READ, PosMax[PosW-1:0], '0);
    send_request(REQ_CHECK, PosMax[PosW-1:0], '0);
    send_request(REQ_DELETE, '0, '0);
  endtask

  // Every operation with extreme words and positions
  task automatic test_value_extremes();
    send_request(REQ_APPEND, PosMax[PosW-1:0], WORD_MAX);
    send_request(REQ_APPEND, '0, WORD_MIN);
    send_request(REQ_INSERT, '0, WORD_ONES);
    send_request(REQ_INSERT, 7'd1, '0);
    send_request(REQ_INSERT, 7'd4, 32'sh5555_AAAA);
    send_request(REQ_INSERT, 7'd6, WORD_MAX);
    send_request(REQ_EDIT, 7'd2, 32'shAAAA_5555);
    send_request(REQ_EDIT, 7'd5, WORD_MAX);
    send_request(REQ_READ, '0, '0);
    send_request(REQ_READ, 7'd2, '0);
    send_request(REQ_READ, 7'd4, '0);
    send_request(REQ_CHECK, 7'd4, '0);
    send_request(REQ_DELETE, 7'd1, '0);
    send_request(REQ_DELETE, 7'd4, '0);
    send_request(REQ_READ, 7'd3, '0);
  endtask

  // Mixed traffic with random content
  task automatic test_random_mix(int n_items);
    int                      pick;
    logic [KindW-1:0]        kind;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      // lean toward growth when nearly empty and toward shrinking when nearly full
      if (shadow_count < 8 && pick >= 50 && pick < 70) pick = pick - 40;
      if (shadow_count > Capacity - 8 && pick < 35) pick = pick + 20;
      if (pick < 15)      kind = REQ_APPEND;
      else if (pick < 35) kind = REQ_INSERT;
      else if (pick < 50) kind = REQ_EDIT;
      else if (pick < 70) kind = REQ_DELETE;
      else if (pick < 85) kind = REQ_READ;
      else if (pick < 97) kind = REQ_CHECK;
      else                kind = $urandom_range(0, 1) ? REQ_UNUSED_6 : REQ_UNUSED_7;
      send_request(kind, pick_pos(), pick_word());
    end
  endtask

  // Fill to capacity, then probe the full array
  task automatic test_full_array();
    while (shadow_count < Capacity) begin
      if ($urandom_range(0, 1)) send_request(REQ_APPEND, PosW'($urandom()), pick_word());
      else send_request(REQ_INSERT, pick_pos(), pick_word());
    end
    send_request(REQ_APPEND, '0, WORD_MAX);
    send_request(REQ_INSERT, '0, WORD_MIN);
    // full is reported ahead of a bad index
    send_request(REQ_INSERT, PosMax[PosW-1:0], WORD_MIN);
    send_request(REQ_READ, PosW'(Capacity - 1), '0);
    send_request(REQ_CHECK, PosW'(Capacity - 1), '0);
    send_request(REQ_EDIT, PosW'(Capacity - 1), WORD_MIN);
    send_request(REQ_READ, PosW'(Capacity), '0);
    send_request(REQ_CHECK, PosW'(Capacity), '0);
    send_request(REQ_EDIT, PosW'(Capacity), WORD_MAX);
    send_request(REQ_DELETE, PosW'(Capacity), '0);
    send_request(REQ_DELETE, PosW'(Capacity - 1), '0);
    send_request(REQ_INSERT, PosW'(Capacity - 1), WORD_MAX);
    send_request(REQ_READ, PosW'(Capacity - 1), '0);
  endtask

  // Delete down to empty with reads in between, then delete once more
  task automatic test_drain_to_empty();
    while (shadow_count > 0) begin
      if ($urandom_range(0, 3) == 0) send_request(REQ_READ, pick_pos(), '0);
      send_request(REQ_DELETE, PosW'($urandom_range(0, shadow_count - 1)), pick_word());
    end
    send_request(REQ_DELETE, '0, '0);
    send_request(REQ_READ, '0, '0);
  endtask

  // Compare each result transaction with the oldest expectation; drive ready
  always @(posedge clk_i) begin : check_results
    array_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no request outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.read_data !== want.read_data) begin
          $error("read_data: expected %0d, got %0d", want.read_data, rsp_if.read_data);
          mismatches++;
        end
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          mismatches++;
        end
        if (rsp_if.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, rsp_if.count);
          mismatches++;
        end
        if (rsp_if.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0b, got %0b", want.is_empty, rsp_if.is_empty);
          mismatches++;
        end
        if (rsp_if.is_full !== want.is_full) begin
          $error("is_full: expected %0b, got %0b", want.is_full, rsp_if.is_full);
          mismatches++;
        end
      end
    end
    rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    shadow_count = 0;
    tx_idle_pct  = 6;
    rx_idle_pct  = 56;
    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= '0;
    req_if.position <= '0;
    req_if.value    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender mostly busy, receiver stalls often
    test_empty_array();
    test_value_extremes();
    test_random_mix(250);

    // sender idles often, receiver mostly ready
    tx_idle_pct = 56;
    rx_idle_pct = 6;
    test_full_array();
    test_random_mix(150);
    test_drain_to_empty();

    // back to back in both directions
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_mix(200);
    test_full_array();
    test_random_mix(100);

    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
